// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// No dependencies; used by tcw_ctrl, tcw_dp and text_console_writer_top.
package tcw_pkg;

    // operation codes
    localparam logic [2:0] FN_PUT       = 3'd0;
    localparam logic [2:0] FN_BACKSPACE = 3'd1;
    localparam logic [2:0] FN_FILL      = 3'd2;
    localparam logic [2:0] FN_SET_CUR   = 3'd3;
    localparam logic [2:0] FN_READ      = 3'd4;

    // configuration register indexes
    localparam logic [0:0] CFG_DEFAULT_ATTR = 1'b0;
    localparam logic [0:0] CFG_ERROR_ATTR   = 1'b1;

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ERROR   = 8'd69;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture the input word
        logic exec;       // run the single-cycle part of the operation
        logic rd_load;    // take read data into the result
        logic clr_step;   // clear one cell at the sweep counter
        logic fill_step;  // fill one cell at the sweep counter
        logic copy_step;  // issue one scroll copy at the sweep counter
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_fill;
        logic go_scroll;
        logic go_read;
        logic swp_last;
    } t_sts;

endpackage

// ===== hw/rtl/tcw_ctrl.sv =====
// Sequencer of the text console writer: clear pass, execute, read wait,
// fill and scroll sweeps. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    output tcw_pkg::t_cmd o_cmd,
    input  tcw_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_FILL,
        ST_SCROLL,
        ST_DRAIN
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    if (i_sts.swp_last) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_start) r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (i_sts.go_fill) begin
                        r_state <= ST_FILL;
                    end else if (i_sts.go_scroll) begin
                        r_state <= ST_SCROLL;
                    end else if (i_sts.go_read) begin
                        r_state <= ST_READ;
                    end else begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                ST_READ: begin
                    r_state <= ST_IDLE;
                    r_done  <= 1'b1;
                end
                ST_FILL: begin
                    if (i_sts.swp_last) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                ST_SCROLL: begin
                    if (i_sts.swp_last) r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    // last copy write lands this cycle
                    r_state <= ST_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.latch     = (r_state == ST_IDLE) && i_start;
        o_cmd.exec      = (r_state == ST_EXEC);
        o_cmd.rd_load   = (r_state == ST_READ);
        o_cmd.clr_step  = (r_state == ST_CLEAR);
        o_cmd.fill_step = (r_state == ST_FILL);
        o_cmd.copy_step = (r_state == ST_SCROLL);
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

// ===== hw/rtl/tcw_dp.sv =====
// Datapath of the text console writer: cell memory, cursor, attribute
// registers, sweep counter and result registers. Depends on tcw_pkg.
module tcw_dp #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcw_pkg::t_cmd i_cmd,
    output tcw_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  logic [2:0]    i_func,
    input  logic [7:0]    i_chr,
    input  logic [7:0]    i_col,
    input  logic [7:0]    i_row,
    input  logic [7:0]    i_attr,
    input  logic [10:0]   i_cell_index,
    output logic [7:0]    o_cell_char,
    output logic [7:0]    o_cell_attr,
    output logic [10:0]   o_cursor_pos,
    output logic          o_overflow,
    output logic          o_scrolled
);

    localparam int NCELLS = COLS * ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(COLS);
    localparam int RW     = $clog2(ROWS);

    localparam logic [6:0]    COLS7      = 7'(COLS);
    localparam logic [6:0]    ROWS7      = 7'(ROWS);
    localparam logic [AW-1:0] COLS_AW    = AW'(COLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(NCELLS - 1);
    localparam logic [AW-1:0] BLANK_FROM = AW'(NCELLS - COLS);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

    // latched input word
    logic [2:0]  r_func;
    logic [7:0]  r_chr;
    logic [7:0]  r_col;
    logic [7:0]  r_row;
    logic [7:0]  r_attr;
    logic [10:0] r_cidx;

    logic [7:0] r_def_attr;
    logic [7:0] r_err_attr;

    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [AW-1:0] r_cur_lin, n_cur_lin;

    logic [15:0]   r_mem [NCELLS];
    logic [15:0]   r_rdata;
    logic [AW-1:0] r_cnt;
    logic          r_cp_v;
    logic          r_cp_zero;
    logic [AW-1:0] r_cp_addr;

    logic [7:0]  r_o_char;
    logic [7:0]  r_o_attr;
    logic [10:0] r_o_cur;
    logic        r_o_ovf;
    logic        r_o_scr;

    // decode of the latched coordinates
    logic          coord_oor;
    logic          coord_neg;
    logic          use_coord;
    logic [RW-1:0] pos_row;
    logic [CW-1:0] pos_col;
    logic [AW-1:0] pos_lin;
    logic [AW-1:0] line_base;
    logic [7:0]    put_attr;
    logic          is_nl;
    logic          wrap;
    logic          put_scroll;
    logic          cidx_ok;

    logic          ex_we;
    logic [AW-1:0] ex_addr;
    logic [15:0]   ex_data;
    logic          ex_ovf;
    logic          ex_scr;
    logic          go_fill;
    logic          go_read;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic [AW-1:0] mem_ra;

    assign coord_oor = (!r_col[7] && (r_col[6:0] >= COLS7)) ||
                       (!r_row[7] && (r_row[6:0] >= ROWS7));
    assign coord_neg = r_col[7] || r_row[7];
    assign use_coord = !coord_neg && !coord_oor;
    assign pos_row   = use_coord ? r_row[RW-1:0] : r_cur_row;
    assign pos_col   = use_coord ? r_col[CW-1:0] : r_cur_col;
    assign pos_lin   = use_coord ? AW'(AW'(r_row[RW-1:0]) * COLS_AW + AW'(r_col[CW-1:0]))
                                 : r_cur_lin;
    assign line_base = AW'(pos_lin - AW'(pos_col));
    assign put_attr  = (r_attr == 8'd0) ? r_def_attr : r_attr;
    assign is_nl     = (r_chr == tcw_pkg::CH_NEWLINE);
    assign wrap      = is_nl || (pos_col == LAST_COL);
    assign put_scroll = wrap && (pos_row == LAST_ROW);
    assign cidx_ok   = (32'(r_cidx) < NCELLS);

    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_cur_lin = r_cur_lin;
        ex_we     = 1'b0;
        ex_addr   = pos_lin;
        ex_data   = {put_attr, r_chr};
        ex_ovf    = 1'b0;
        ex_scr    = 1'b0;
        go_fill   = 1'b0;
        go_read   = 1'b0;
        case (r_func)
            tcw_pkg::FN_PUT: begin
                if (coord_oor) begin
                    ex_we   = 1'b1;
                    ex_addr = LAST_CELL;
                    ex_data = {r_err_attr, tcw_pkg::CH_ERROR};
                    ex_ovf  = 1'b1;
                end else begin
                    ex_we  = !is_nl;
                    ex_scr = put_scroll;
                    if (!wrap) begin
                        n_cur_row = pos_row;
                        n_cur_col = CW'(pos_col + 1'b1);
                        n_cur_lin = AW'(pos_lin + 1'b1);
                    end else if (put_scroll) begin
                        // stay on the bottom row after the scroll
                        n_cur_row = pos_row;
                        n_cur_col = '0;
                        n_cur_lin = line_base;
                    end else begin
                        n_cur_row = RW'(pos_row + 1'b1);
                        n_cur_col = '0;
                        n_cur_lin = AW'(line_base + COLS_AW);
                    end
                end
            end
            tcw_pkg::FN_BACKSPACE: begin
                ex_we   = 1'b1;
                ex_data = {r_def_attr, tcw_pkg::CH_SPACE};
                if (r_cur_col != '0) begin
                    ex_addr   = AW'(r_cur_lin - 1'b1);
                    n_cur_col = CW'(r_cur_col - 1'b1);
                    n_cur_lin = AW'(r_cur_lin - 1'b1);
                end else begin
                    ex_addr = r_cur_lin;
                end
            end
            tcw_pkg::FN_FILL: begin
                go_fill   = 1'b1;
                n_cur_row = LAST_ROW;
                n_cur_col = LAST_COL;
                n_cur_lin = LAST_CELL;
            end
            tcw_pkg::FN_SET_CUR: begin
                if (use_coord) begin
                    n_cur_row = pos_row;
                    n_cur_col = pos_col;
                    n_cur_lin = pos_lin;
                end else begin
                    ex_ovf = 1'b1;
                end
            end
            tcw_pkg::FN_READ: begin
                if (cidx_ok) go_read = 1'b1;
                else         ex_ovf  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.go_fill   = go_fill;
    assign o_sts.go_scroll = ex_scr;
    assign o_sts.go_read   = go_read;
    assign o_sts.swp_last  = (r_cnt == LAST_CELL);

    // memory port selection: the delayed scroll copy owns the write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt;
        mem_wd = '0;
        if (r_cp_v) begin
            mem_we = 1'b1;
            mem_wa = r_cp_addr;
            mem_wd = r_cp_zero ? 16'd0 : r_rdata;
        end else if (i_cmd.exec) begin
            mem_we = ex_we;
            mem_wa = ex_addr;
            mem_wd = ex_data;
        end else if (i_cmd.fill_step) begin
            mem_we = 1'b1;
            mem_wd = {r_attr, r_chr};
        end else if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.copy_step) begin
            mem_ra = (r_cnt >= BLANK_FROM) ? '0 : AW'(r_cnt + COLS_AW);
        end else begin
            mem_ra = AW'(r_cidx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_cp_v <= 1'b0;
        end else begin
            r_cp_v <= i_cmd.copy_step;
            if (i_cmd.exec) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.fill_step || i_cmd.copy_step) begin
                r_cnt <= AW'(r_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_cnt;
        r_cp_zero <= (r_cnt >= BLANK_FROM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr <= tcw_pkg::DEFAULT_ATTR_RST;
            r_err_attr <= tcw_pkg::ERROR_ATTR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcw_pkg::CFG_DEFAULT_ATTR: r_def_attr <= i_cfg_data;
                tcw_pkg::CFG_ERROR_ATTR:   r_err_attr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_cur_lin <= '0;
        end else if (i_cmd.exec) begin
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_cur_lin <= n_cur_lin;
        end
    end

    // hold the input word for the whole operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_chr  <= i_chr;
            r_col  <= i_col;
            r_row  <= i_row;
            r_attr <= i_attr;
            r_cidx <= i_cell_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_char <= '0;
            r_o_attr <= '0;
            r_o_cur  <= 11'(n_cur_lin);
            r_o_ovf  <= ex_ovf;
            r_o_scr  <= ex_scr;
        end else if (i_cmd.rd_load) begin
            r_o_char <= r_rdata[7:0];
            r_o_attr <= r_rdata[15:8];
        end
    end

    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;
    assign o_cursor_pos = r_o_cur;
    assign o_overflow   = r_o_ovf;
    assign o_scrolled   = r_o_scr;

endmodule

// ===== hw/rtl/text_console_writer_top.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
//
// Usage:
//   Command channel: a word (i_func, i_chr, i_col, i_row, i_attr,
//   i_cell_index) is taken at a rising edge with start high and busy low.
//   Each word gives one result word on o_cell_char, o_cell_attr,
//   o_cursor_pos, o_overflow and o_scrolled, marked by a one-cycle o_done.
//   The receiver cannot stall; the result must be taken in that cycle.
//   States passed from the accept edge to o_done:
//     put, backspace, set cursor, unused codes: execute only
//     read cell: execute and read wait (one registered memory read)
//     fill screen: execute and fill sweep (one cell written per cycle)
//     put that scrolls: execute, scroll sweep (one cell copied per cycle,
//       reads and writes on separate ports of the cell memory) and drain
//   A new word can be accepted in the o_done cycle. Attribute registers
//   are written through i_cfg_* at any edge with i_cfg_we high.
//   Reset: a clearing pass writes zero to all COLS*ROWS cells, one per
//   cycle, with busy high; cursor goes to cell 0.
module text_console_writer_top #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_chr,
    input  logic signed [7:0] i_col,
    input  logic signed [7:0] i_row,
    input  logic [7:0]        i_attr,
    input  logic [10:0]       i_cell_index,
    output logic [7:0]        o_cell_char,
    output logic [7:0]        o_cell_attr,
    output logic [10:0]       o_cursor_pos,
    output logic              o_overflow,
    output logic              o_scrolled
);

    localparam int NCELLS = COLS * ROWS;

    tcw_pkg::t_cmd cmd;
    tcw_pkg::t_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    tcw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_chr        (i_chr),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_attr       (i_attr),
        .i_cell_index (i_cell_index),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_pos (o_cursor_pos),
        .o_overflow   (o_overflow),
        .o_scrolled   (o_scrolled)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((32'(o_cursor_pos) < NCELLS) || (NCELLS > 2048)))
        else $error("cursor outside the screen");

endmodule
